### hdl/eocc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eocc_pkg
// Shared types, constants and trig helpers for the ellipse obstacle check.
// ----------------------------------------------------------------------------
package eocc_pkg;

    localparam int FRAMES_DEF  = 64;
    localparam int CIRCLES_DEF = 4;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;

    // Transaction function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_OFS0    = 3'd0,
        REG_OFS1    = 3'd1,
        REG_OFS2    = 3'd2,
        REG_OFS3    = 3'd3,
        REG_INV_A   = 3'd4,
        REG_INV_B   = 3'd5,
        REG_FILTER  = 3'd6,
        REG_UNUSED  = 3'd7
    } t_reg_idx;

    localparam logic signed [11:0] OFS0_RST   = -12'sd384;
    localparam logic signed [11:0] OFS1_RST   = -12'sd128;
    localparam logic signed [11:0] OFS2_RST   = 12'sd128;
    localparam logic signed [11:0] OFS3_RST   = 12'sd384;
    localparam logic [20:0]        INV_A_RST  = 21'd65536;
    localparam logic [20:0]        INV_B_RST  = 21'd262144;
    localparam logic [39:0]        FILTER_RST = 40'd26214400;

    // Quarter-wave sine table, Q14
    function automatic logic [14:0] quarter_sine(input logic [4:0] k);
        logic [14:0] v;
        unique case (k)
            5'd0:  v = 15'd0;
            5'd1:  v = 15'd1606;
            5'd2:  v = 15'd3196;
            5'd3:  v = 15'd4756;
            5'd4:  v = 15'd6270;
            5'd5:  v = 15'd7723;
            5'd6:  v = 15'd9102;
            5'd7:  v = 15'd10394;
            5'd8:  v = 15'd11585;
            5'd9:  v = 15'd12665;
            5'd10: v = 15'd13623;
            5'd11: v = 15'd14449;
            5'd12: v = 15'd15137;
            5'd13: v = 15'd15679;
            5'd14: v = 15'd16069;
            5'd15: v = 15'd16305;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // Q14 sine of a 16-bit turn angle, interpolated, round half up
    function automatic logic signed [15:0] sin_q14(input logic [15:0] h);
        logic [1:0]  q;
        logic [14:0] p;
        logic [4:0]  idx;
        logic [9:0]  fr;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [20:0] prod;
        logic [14:0] v;
        q    = h[15:14];
        p    = q[0] ? 15'(15'd16384 - {1'b0, h[13:0]}) : {1'b0, h[13:0]};
        idx  = p[14:10];
        fr   = p[9:0];
        lo   = quarter_sine(idx);
        hi   = quarter_sine(5'(idx + 5'd1));
        prod = 21'(21'(hi - lo) * 21'(fr)) + 21'd512;
        if (idx[4]) begin
            v = 15'd16384;
        end else begin
            v = 15'(lo + 15'(prod[20:10]));
        end
        return q[1] ? 16'(-$signed({1'b0, v})) : $signed({1'b0, v});
    endfunction

endpackage

### hdl/ellipse_obstacle_collision_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_obstacle_collision_check
// Per-frame obstacle pose table with an ellipse-versus-ego-circles test.
// ----------------------------------------------------------------------------
// A query result is registered through every pipeline stage and shows on
// o_valid from the output register; its handshake waits while i_stall is high.
// Throughput: one transaction per cycle while o_stall is low, loads and queries mixed freely.
// Loads write the pose table in the accept cycle and give no result.
// Stages advance independently, so bubbles collapse under output stall.
// Reset clears all stage valids and loads register defaults; the pose table
// is not cleared and a frame holds garbage until it is loaded.
module ellipse_obstacle_collision_check
    import eocc_pkg::*;
#(
    parameter int FRAMES  = FRAMES_DEF,
    parameter int CIRCLES = CIRCLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // query / load channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_func,
    input  logic [5:0]                i_frame,
    input  logic signed [23:0]        i_pos_x,
    input  logic signed [23:0]        i_pos_y,
    input  logic [15:0]               i_heading,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_collides,
    output logic                      o_near,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    localparam int AW = $clog2(FRAMES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [11:0] r_ofs [4];
    logic [20:0]        r_inv_a;
    logic [20:0]        r_inv_b;
    logic [39:0]        r_filter;
    t_reg_idx           w_reg_idx;
    logic               w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[5:3]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs[0] <= OFS0_RST;
            r_ofs[1] <= OFS1_RST;
            r_ofs[2] <= OFS2_RST;
            r_ofs[3] <= OFS3_RST;
            r_inv_a  <= INV_A_RST;
            r_inv_b  <= INV_B_RST;
            r_filter <= FILTER_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_OFS0:   r_ofs[0] <= pwdata[11:0];
                REG_OFS1:   r_ofs[1] <= pwdata[11:0];
                REG_OFS2:   r_ofs[2] <= pwdata[11:0];
                REG_OFS3:   r_ofs[3] <= pwdata[11:0];
                REG_INV_A:  r_inv_a  <= pwdata[20:0];
                REG_INV_B:  r_inv_b  <= pwdata[20:0];
                REG_FILTER: r_filter <= pwdata[39:0];
                default: ;  // drop writes past the map
            endcase
        end
    end

    // Read back, zero-extended
    always_comb begin
        unique case (w_reg_idx)
            REG_OFS0:   prdata = {52'd0, r_ofs[0]};
            REG_OFS1:   prdata = {52'd0, r_ofs[1]};
            REG_OFS2:   prdata = {52'd0, r_ofs[2]};
            REG_OFS3:   prdata = {52'd0, r_ofs[3]};
            REG_INV_A:  prdata = {43'd0, r_inv_a};
            REG_INV_B:  prdata = {43'd0, r_inv_b};
            REG_FILTER: prdata = {24'd0, r_filter};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: stage k loads when it is empty or drains.
    // Stage 8 is the output register.
    // ------------------------------------------------------------------
    logic [8:1] r_vld;
    logic [8:1] w_en;
    logic       w_acc;

    always_comb begin
        w_en[8] = !r_vld[8] || !i_stall;
        for (int k = 7; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[1];
    assign w_acc   = i_valid && w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= w_acc && (i_func == FUNC_QUERY);
            end
            for (int k = 2; k <= 8; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pose table. Loads write on accept, queries read on accept;
    // at most one transaction per edge, so no same-entry overlap exists.
    // ------------------------------------------------------------------
    logic [63:0]     r_track [FRAMES];
    logic [AW+5:0]   w_frame_ext;
    logic [AW-1:0]   w_addr;
    logic            w_in_range;

    assign w_frame_ext = {{AW{1'b0}}, i_frame};
    assign w_addr      = w_frame_ext[AW-1:0];
    assign w_in_range  = w_frame_ext < (AW+6)'(FRAMES);

    logic               r1_ok;
    logic signed [23:0] r1_px;
    logic signed [23:0] r1_py;
    logic [15:0]        r1_hd;
    logic [63:0]        r1_ent;

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_func == FUNC_LOAD) && w_in_range) begin
            r_track[w_addr] <= {i_heading, i_pos_y, i_pos_x};
        end
        if (w_en[1]) begin
            if (w_in_range) begin
                r1_ent <= r_track[w_addr];
            end
            r1_ok <= w_in_range;
            r1_px <= i_pos_x;
            r1_py <= i_pos_y;
            r1_hd <= i_heading;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: centre deltas and the four Q14 trig values
    // ------------------------------------------------------------------
    logic               r2_ok;
    logic signed [24:0] r2_dx;
    logic signed [24:0] r2_dy;
    logic signed [15:0] r2_co;
    logic signed [15:0] r2_so;
    logic signed [15:0] r2_ce;
    logic signed [15:0] r2_se;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_ok <= r1_ok;
            r2_dx <= 25'(r1_px) - 25'($signed(r1_ent[23:0]));
            r2_dy <= 25'(r1_py) - 25'($signed(r1_ent[47:24]));
            r2_co <= sin_q14(16'(r1_ent[63:48] + 16'd16384));
            r2_so <= sin_q14(r1_ent[63:48]);
            r2_ce <= sin_q14(16'(r1_hd + 16'd16384));
            r2_se <= sin_q14(r1_hd);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared deltas and circle centres (units 2^-22 m)
    // ------------------------------------------------------------------
    logic               r3_ok;
    logic [48:0]        r3_dxx;
    logic [48:0]        r3_dyy;
    logic signed [15:0] r3_co;
    logic signed [15:0] r3_so;
    logic signed [39:0] r3_cx [CIRCLES];
    logic signed [39:0] r3_cy [CIRCLES];
    logic signed [49:0] w_dxx;
    logic signed [49:0] w_dyy;

    assign w_dxx = 50'(r2_dx) * 50'(r2_dx);
    assign w_dyy = 50'(r2_dy) * 50'(r2_dy);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_ok  <= r2_ok;
            r3_dxx <= w_dxx[48:0];
            r3_dyy <= w_dyy[48:0];
            r3_co  <= r2_co;
            r3_so  <= r2_so;
            for (int c = 0; c < CIRCLES; c++) begin
                r3_cx[c] <= (40'(r2_dx) <<< 14) + 40'(28'(r_ofs[c]) * 28'(r2_ce));
                r3_cy[c] <= (40'(r2_dy) <<< 14) + 40'(28'(r_ofs[c]) * 28'(r2_se));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: near prefilter and rotation products
    // ------------------------------------------------------------------
    logic               r4_near;
    logic signed [55:0] r4_pcc [CIRCLES];
    logic signed [55:0] r4_pss [CIRCLES];
    logic signed [55:0] r4_pcs [CIRCLES];
    logic signed [55:0] r4_psc [CIRCLES];
    logic [49:0]        w_dist;

    assign w_dist = 50'(r3_dxx) + 50'(r3_dyy);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_near <= r3_ok && (w_dist <= 50'(r_filter));
            for (int c = 0; c < CIRCLES; c++) begin
                r4_pcc[c] <= 56'(r3_cx[c]) * 56'(r3_co);
                r4_pss[c] <= 56'(r3_cy[c]) * 56'(r3_so);
                r4_pcs[c] <= 56'(r3_cx[c]) * 56'(r3_so);
                r4_psc[c] <= 56'(r3_cy[c]) * 56'(r3_co);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: u, w in 2^-36 m, magnitude rounded to 1/256 m
    // ------------------------------------------------------------------
    function automatic logic [28:0] round_mag(input logic signed [56:0] v);
        logic [56:0] m;
        logic [56:0] s;
        m = v[56] ? 57'(-v) : 57'(v);
        s = 57'(m + 57'd134217728);
        return s[56:28];
    endfunction

    logic        r5_near;
    logic [28:0] r5_ur [CIRCLES];
    logic [28:0] r5_wr [CIRCLES];

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_near <= r4_near;
            for (int c = 0; c < CIRCLES; c++) begin
                r5_ur[c] <= round_mag(57'(r4_pcc[c]) + 57'(r4_pss[c]));
                r5_wr[c] <= round_mag(57'(r4_pcs[c]) - 57'(r4_psc[c]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: squares (2^-16 m^2)
    // ------------------------------------------------------------------
    logic        r6_near;
    logic [57:0] r6_usq [CIRCLES];
    logic [57:0] r6_wsq [CIRCLES];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_near <= r5_near;
            for (int c = 0; c < CIRCLES; c++) begin
                r6_usq[c] <= 58'(r5_ur[c]) * 58'(r5_ur[c]);
                r6_wsq[c] <= 58'(r5_wr[c]) * 58'(r5_wr[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: scale by 1/a^2, 1/b^2; flag far components
    // ------------------------------------------------------------------
    logic        r7_near;
    logic [56:0] r7_ta [CIRCLES];
    logic [56:0] r7_tb [CIRCLES];
    logic        r7_fa [CIRCLES];
    logic        r7_fb [CIRCLES];

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_near <= r6_near;
            for (int c = 0; c < CIRCLES; c++) begin
                r7_ta[c] <= 57'(r6_usq[c][35:0]) * 57'(r_inv_a);
                r7_tb[c] <= 57'(r6_wsq[c][35:0]) * 57'(r_inv_b);
                r7_fa[c] <= (r_inv_a != '0) && (r6_usq[c][57:36] != '0);
                r7_fb[c] <= (r_inv_b != '0) && (r6_wsq[c][57:36] != '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: ellipse test per circle, OR across circles, output register
    // ------------------------------------------------------------------
    logic        w_hit;
    logic [57:0] w_sum [CIRCLES];
    logic        r_collides;
    logic        r_near;

    always_comb begin
        w_hit = 1'b0;
        for (int c = 0; c < CIRCLES; c++) begin
            w_sum[c] = 58'(r7_ta[c]) + 58'(r7_tb[c]);
            if (!r7_fa[c] && !r7_fb[c] && (w_sum[c][57:36] == '0)) begin
                w_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_near     <= r7_near;
            r_collides <= r7_near && w_hit;
        end
    end

    assign o_valid    = r_vld[8];
    assign o_near     = r_near;
    assign o_collides = r_collides;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_collide_needs_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_collides |-> o_near)
        else $error("collision reported without passing the near filter");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled while the pipeline has a free slot");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ellipse obstacle collision check. Loads obstacle
// poses per frame, sends ego pose queries and checks every collides/near
// answer against a bit-exact fixed-point collision predictor, across several
// register settings, with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
    import eocc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 200;

    typedef struct packed {
        logic collides;
        logic near;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_func;
    logic [5:0]         i_frame;
    logic signed [23:0] i_pos_x;
    logic signed [23:0] i_pos_y;
    logic [15:0]        i_heading;
    logic               o_valid;
    logic               i_stall;
    logic               o_collides;
    logic               o_near;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    ellipse_obstacle_collision_check i_dut (.*);

    // Predictor state: pose table and register shadow
    logic signed [23:0] track_x   [64];
    logic signed [23:0] track_y   [64];
    logic [15:0]        track_hd  [64];
    bit                 loaded    [64];
    longint             ofs       [4];
    longint unsigned    inv_a;
    longint unsigned    inv_b;
    longint unsigned    filter_sq;

    t_verdict           pending_verdicts[$];
    int unsigned        sine_tab[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394,
                                         11585, 12665, 13623, 14449, 15137, 15679,
                                         16069, 16305, 16384};
    int                 mismatches;
    int                 quiet_cycles;
    bit                 idle_on;
    bit                 hold_req;

    // Q14 sine of a 16-bit turn angle, interpolated from the quarter-wave table
    function automatic longint sine_q14(bit [15:0] h);
        bit [1:0]    q;
        int unsigned p, idx, fr, v;
        q   = h[15:14];
        p   = q[0] ? (16384 - h[13:0]) : h[13:0];
        idx = p >> 10;
        fr  = p & 1023;
        if (idx >= 16) begin
            v = 16384;
        end else begin
            v = sine_tab[idx] + (((sine_tab[idx+1] - sine_tab[idx]) * fr + 512) >> 10);
        end
        return q[1] ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned round_to_lsb(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        return (m + (64'd1 << 27)) >> 28;
    endfunction

    // Component term; far when the square reaches 2^36 with a nonzero reciprocal
    function automatic bit axis_term(longint unsigned sq, longint unsigned inv,
                                     output longint unsigned term);
        term = 0;
        if (inv == 0) return 1'b0;
        if (sq >= (64'd1 << 36)) return 1'b1;
        term = sq * inv;
        return 1'b0;
    endfunction

    function automatic t_verdict ellipse_verdict(int fr, longint px, longint py,
                                                 bit [15:0] hd);
        t_verdict        res;
        longint          dx, dy, co, so, ce, se, cx, cy;
        longint unsigned dist_sq, ur, wr, ta, tb_t;
        bit              far_a, far_b;
        res     = '0;
        dx      = px - longint'(track_x[fr]);
        dy      = py - longint'(track_y[fr]);
        dist_sq = dx * dx + dy * dy;
        if (dist_sq > filter_sq) return res;
        res.near = 1'b1;
        co = sine_q14(track_hd[fr] + 16'd16384);
        so = sine_q14(track_hd[fr]);
        ce = sine_q14(hd + 16'd16384);
        se = sine_q14(hd);
        for (int i = 0; i < 4; i++) begin
            cx    = dx * 16384 + ofs[i] * ce;
            cy    = dy * 16384 + ofs[i] * se;
            ur    = round_to_lsb(cx * co + cy * so);
            wr    = round_to_lsb(cx * so - cy * co);
            far_a = axis_term(ur * ur, inv_a, ta);
            far_b = axis_term(wr * wr, inv_b, tb_t);
            if (!far_a && !far_b && (ta + tb_t) < (64'd1 << 36)) begin
                res.collides = 1'b1;
                break;
            end
        end
        return res;
    endfunction

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected (collides=%0b near=%0b)",
                             o_collides, o_near);
            end else begin
                want = pending_verdicts.pop_front();
                if (want.collides !== o_collides || want.near !== o_near) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: collides exp %0b got %0b, near exp %0b got %0b",
                                 want.collides, o_collides, want.near, o_near);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver stall: random bursts, plus one long hold on request
    initial begin
        int left;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                left     = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (left > 0) begin
                i_stall <= 1'b1;
                left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                left = $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Send one transaction, predicting its result at acceptance
    task automatic send_item(logic func, logic [5:0] fr, logic [23:0] x, logic [23:0] y,
                             logic [15:0] hd);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_func    <= func;
        i_frame   <= fr;
        i_pos_x   <= x;
        i_pos_y   <= y;
        i_heading <= hd;
        do @(posedge i_clk); while (o_stall);
        if (func == FUNC_LOAD) begin
            track_x[fr]  = x;
            track_y[fr]  = y;
            track_hd[fr] = hd;
            loaded[fr]   = 1'b1;
        end else begin
            pending_verdicts.push_back(ellipse_verdict(fr, longint'($signed(x)),
                                                       longint'($signed(y)), hd));
        end
    endtask

    // Drop valid and wait until all results are back and the pipe is empty
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_OFS0, REG_OFS1, REG_OFS2, REG_OFS3:
                ofs[idx] = longint'($signed(value[11:0]));
            REG_INV_A:  inv_a     = value[20:0];
            REG_INV_B:  inv_b     = value[20:0];
            REG_FILTER: filter_sq = value[39:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [11:0] o0, logic [11:0] o1, logic [11:0] o2,
                              logic [11:0] o3, logic [20:0] ia, logic [20:0] ib,
                              logic [39:0] nf);
        drain();
        write_reg(REG_OFS0, 64'(o0));
        write_reg(REG_OFS1, 64'(o1));
        write_reg(REG_OFS2, 64'(o2));
        write_reg(REG_OFS3, 64'(o3));
        write_reg(REG_INV_A, 64'(ia));
        write_reg(REG_INV_B, 64'(ib));
        write_reg(REG_FILTER, 64'(nf));
    endtask

    // Extremes of fields, every quadrant, exact overlap, and the not-near case
    task automatic test_directed();
        send_item(FUNC_LOAD, 6'd0, 24'h800000, 24'h7FFFFF, 16'd0);
        send_item(FUNC_LOAD, 6'd63, 24'h7FFFFF, 24'h800000, 16'hFFFF);
        send_item(FUNC_LOAD, 6'd21, 24'd0, 24'd0, 16'd16384);
        send_item(FUNC_QUERY, 6'd0, 24'h800000, 24'h7FFFFF, 16'd0);
        send_item(FUNC_QUERY, 6'd63, 24'h7FFFFF, 24'h800000, 16'hFFFF);
        send_item(FUNC_QUERY, 6'd0, 24'h7FFFFF, 24'h800000, 16'd32768);
        for (int q = 0; q < 4; q++)
            send_item(FUNC_QUERY, 6'd21, 24'(q * 200), 24'(-q * 150), 16'(q * 16384));
        send_item(FUNC_QUERY, 6'd21, 24'd6000, 24'd0, 16'd8192);
        send_item(FUNC_QUERY, 6'd21, 24'd0, 24'd5121, 16'd49152);
        send_item(FUNC_QUERY, 6'd21, 24'd600, 24'd90, 16'hAAAA);
        send_item(FUNC_QUERY, 6'd21, 24'd0, 24'd400, 16'h5555);
    endtask

    // Far component: near filter opened wide, ego a long way off on one axis
    task automatic test_far_component();
        set_config(12'h800, 12'h7FF, 12'h000, 12'h7FF, 21'd1048576, 21'd1048576,
                   40'hFF_FFFF_FFFF);
        send_item(FUNC_LOAD, 6'd5, 24'd0, 24'd0, 16'd0);
        send_item(FUNC_QUERY, 6'd5, 24'd384000, 24'd0, 16'd0);
        send_item(FUNC_QUERY, 6'd5, 24'd0, 24'd384000, 16'd0);
        set_config(12'h800, 12'h7FF, 12'h000, 12'h7FF, 21'd0, 21'd1048576,
                   40'hFF_FFFF_FFFF);
        send_item(FUNC_QUERY, 6'd5, 24'd384000, 24'd0, 16'd0);
        send_item(FUNC_QUERY, 6'd5, 24'd384000, 24'd100, 16'd0);
        set_config(12'h800, 12'h7FF, 12'h000, 12'h7FF, 21'd1048576, 21'd0,
                   40'hFF_FFFF_FFFF);
        send_item(FUNC_QUERY, 6'd5, 24'd0, 24'd384000, 16'd16384);
        send_item(FUNC_QUERY, 6'd5, 24'd200, 24'd384000, 16'd0);
    endtask

    // Random traffic: mostly queries close to a loaded obstacle, some noise
    task automatic test_random(int count, int spread);
        int          fr;
        int          roll;
        logic [23:0] x, y;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            fr   = $urandom_range(0, 63);
            if (roll < 20 || !loaded[fr]) begin
                if ($urandom_range(0, 4) == 0) begin
                    x = 24'($urandom);
                    y = 24'($urandom);
                end else begin
                    x = 24'($signed($urandom_range(0, 400000)) - 200000);
                    y = 24'($signed($urandom_range(0, 400000)) - 200000);
                end
                send_item(FUNC_LOAD, 6'(fr), x, y, 16'($urandom));
            end else if (roll < 30) begin
                send_item(FUNC_QUERY, 6'(fr), 24'($urandom), 24'($urandom), 16'($urandom));
            end else begin
                x = track_x[fr] + 24'($signed($urandom_range(0, 2 * spread)) - spread);
                y = track_y[fr] + 24'($signed($urandom_range(0, 2 * spread)) - spread);
                send_item(FUNC_QUERY, 6'(fr), x, y, 16'($urandom));
            end
        end
    endtask

    // Long receiver hold while queries keep coming, then a pause to empty
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(80, 800);
        drain();
        test_random(40, 800);
    endtask

    task automatic test_fill_track();
        for (int f = 0; f < 64; f++)
            send_item(FUNC_LOAD, 6'(f), 24'($signed($urandom_range(0, 40000)) - 20000),
                      24'($signed($urandom_range(0, 40000)) - 20000), 16'($urandom));
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_func    = 1'b0;
        i_frame   = '0;
        i_pos_x   = '0;
        i_pos_y   = '0;
        i_heading = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        idle_on      = 1'b1;
        foreach (loaded[f]) loaded[f] = 1'b0;
        ofs[0]    = -384;
        ofs[1]    = -128;
        ofs[2]    = 128;
        ofs[3]    = 384;
        inv_a     = 65536;
        inv_b     = 262144;
        filter_sq = 26214400;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_track();
        test_random(300, 1500);
        test_far_component();
        test_random(200, 3000);
        set_config(12'hE80, 12'hF80, 12'h080, 12'h180, 21'd65536, 21'd262144, 40'd0);
        test_random(120, 600);
        set_config(12'(-384), 12'(-128), 12'd128, 12'd384, 21'd65536, 21'd262144,
                   40'd26214400);
        test_backpressure();
        set_config(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   21'($urandom_range(0, 1048576)), 21'($urandom_range(0, 1048576)),
                   40'($urandom_range(0, 32'h7FFF_FFFF)));
        test_random(300, 2000);
        set_config(12'h7FF, 12'h800, 12'h7FF, 12'h800, 21'd8192, 21'd32768,
                   40'd104857600);
        idle_on = 1'b0;
        test_random(280, 3000);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
hdl/eocc_pkg.sv
hdl/ellipse_obstacle_collision_check.sv
tb/tb.sv
